// File: rtl/core/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash index map.
// ----------------------------------------------------------------------------
`default_nettype none

package chm_pkg;

    localparam int POOL_ENTRIES = 1024;
    localparam int MAX_CHAINS   = 256;

    localparam int IDX_W      = 10;
    localparam int LINK_W     = IDX_W + 1;
    localparam int CHAIN_W    = $clog2(MAX_CHAINS);
    localparam int KEY_W      = 64;
    localparam int LOG2_W     = 4;
    localparam int STEP_W     = $clog2(POOL_ENTRIES + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // floor(log2(MAX_CHAINS)): largest usable chain_count_log2
    localparam logic [LOG2_W-1:0] LOG2_LIMIT     = LOG2_W'($clog2(MAX_CHAINS + 1) - 1);
    localparam logic [LOG2_W-1:0] LOG2_RESET     = 4'd8;
    localparam logic [LINK_W-1:0] LINK_NIL       = {LINK_W{1'b1}};
    localparam logic [LINK_W-1:0] POOL_LIMIT     = LINK_W'(POOL_ENTRIES);
    localparam logic [STEP_W-1:0] STEP_LIMIT     = STEP_W'(POOL_ENTRIES);

    localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LOG2 = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_HEAD,
        ST_LINK,
        ST_WALK,
        ST_DONE
    } map_state_t;

    typedef struct packed {
        logic             done;
        logic [KEY_W-1:0] value;
    } hash_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/chm_req_if.sv
// ----------------------------------------------------------------------------
// chm_req_if
// Request channel: insert or query items with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface chm_req_if import chm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] element_index;
    logic [KEY_W-1:0] lookup_key;

    modport source (output valid, output req_type, output element_index,
                    output lookup_key, input ready);
    modport sink   (input valid, input req_type, input element_index,
                    input lookup_key, output ready);
endinterface

`default_nettype wire

// File: rtl/core/chm_rsp_if.sv
// ----------------------------------------------------------------------------
// chm_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface chm_rsp_if import chm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] found_index;

    modport source (output valid, output found, output found_index, input ready);
    modport sink   (input valid, input found, input found_index, output ready);
endinterface

`default_nettype wire

// File: rtl/core/chm_cfg_if.sv
// ----------------------------------------------------------------------------
// chm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface chm_cfg_if import chm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/chm_ram.sv
// ----------------------------------------------------------------------------
// chm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/chm_hash.sv
// ----------------------------------------------------------------------------
// chm_hash
// 64-bit mix finalizer on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module chm_hash import chm_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [KEY_W-1:0] din,
    output hash_rsp_t             rsp
);

    logic             active_reg;
    logic             round_reg;
    logic             done_reg;
    logic [1:0]       step_reg;
    logic [KEY_W-1:0] x_reg;
    logic [KEY_W-1:0] acc_reg;
    logic [KEY_W-1:0] prod_reg;

    logic [KEY_W-1:0] coef;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    logic [KEY_W-1:0] mul;
    logic [KEY_W-1:0] acc_sum;
    logic [KEY_W-1:0] mixed;

    // low 64 bits of x * c: x_lo*c_lo + ((x_lo*c_hi + x_hi*c_lo) << 32)
    always_comb
    begin
        coef = round_reg ? MIX_C2 : MIX_C1;
        unique case (step_reg)
            2'd1:
            begin
                op_a = x_reg[31:0];
                op_b = coef[63:32];
            end
            2'd2:
            begin
                op_a = x_reg[63:32];
                op_b = coef[31:0];
            end
            default:
            begin
                op_a = x_reg[31:0];
                op_b = coef[31:0];
            end
        endcase
        mul     = {32'd0, op_a} * {32'd0, op_b};
        acc_sum = acc_reg + {prod_reg[31:0], 32'd0};
        mixed   = acc_sum ^ (acc_sum >> 33);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            round_reg  <= 1'b0;
            done_reg   <= 1'b0;
            step_reg   <= 2'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                round_reg  <= 1'b0;
                step_reg   <= 2'd0;
            end
            else if (active_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    if (round_reg)
                    begin
                        active_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                    round_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= din ^ (din >> 33);
        end
        else if (active_reg)
        begin
            prod_reg <= mul;
            unique case (step_reg)
                2'd0: acc_reg <= acc_reg;
                2'd1: acc_reg <= prod_reg;
                2'd2: acc_reg <= acc_sum;
                2'd3: x_reg   <= mixed;
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = x_reg;

endmodule

`default_nettype wire

// File: rtl/core/chained_hash_index_map.sv
// ----------------------------------------------------------------------------
// chained_hash_index_map
// Hash map of pool slot indices with separate chaining.
// ----------------------------------------------------------------------------
// req carries one item at a time: req_type 0 inserts element_index under
// lookup_key at the head of its chain, req_type 1 looks lookup_key up. Each
// item gives one rsp item (found, found_index). cfg writes hash_seed
// (index 0) and chain_count_log2 (index 1); it is always ready.
// req is ready only while the block is idle. The key is hashed on one
// shared 32x32 multiplier; then the chain head is read. rsp is valid in
// ST_DONE. An insert reaches it after ST_HASH and ST_HEAD (and ST_LINK
// when the chain was not empty); a query after ST_HASH, ST_HEAD and, for
// a non-empty chain, ST_WALK, which visits one chain slot a cycle through
// the key and link memories, at most 1024. With rsp ready the rsp item is
// accepted in the cycle it turns valid, and the next req item can be taken
// in the cycle after that. While rsp is stalled the result is held and req
// stays not ready.
// Reset empties every chain at once (one valid bit per chain head) and
// loads hash_seed = 0, chain_count_log2 = 8.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_index_map import chm_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp,
    chm_cfg_if.sink   cfg
);

    map_state_t state_reg, state_next;

    logic [KEY_W-1:0]      seed_reg;
    logic [LOG2_W-1:0]     log2_reg;
    logic [MAX_CHAINS-1:0] head_valid_reg, head_valid_next;

    logic                  req_type_reg, req_type_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [CHAIN_W-1:0]    chain_reg, chain_next;
    logic [LINK_W-1:0]     cur_reg, cur_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      found_index_reg, found_index_next;

    hash_rsp_t             hash_rsp;
    logic                  hash_start;
    logic [KEY_W-1:0]      hash_din;

    logic [LOG2_W-1:0]     lg_sat;
    logic [CHAIN_W:0]      chain_mask;
    logic [CHAIN_W-1:0]    chain_sel;

    logic                  head_rd_en;
    logic                  head_wr_en;
    logic [LINK_W-1:0]     head_q;
    logic [LINK_W-1:0]     head_value;

    logic                  key_wr_en;
    logic                  walk_rd_en;
    logic [IDX_W-1:0]      walk_addr;
    logic [KEY_W-1:0]      key_q;
    logic                  next_wr_en;
    logic [LINK_W-1:0]     next_q;

    logic                  prev_wr_en;
    logic [IDX_W-1:0]      prev_addr;
    logic [LINK_W-1:0]     prev_data;

    logic                  in_pool;
    logic [STEP_W-1:0]     steps_inc;

    chm_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .din   (hash_din),
        .rsp   (hash_rsp)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_CHAINS)) u_heads (
        .clk     (clk),
        .wr_en   (head_wr_en),
        .wr_addr (chain_reg),
        .wr_data ({1'b0, idx_reg}),
        .rd_en   (head_rd_en),
        .rd_addr (chain_sel),
        .rd_data (head_q)
    );

    chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (req.element_index),
        .wr_data (req.lookup_key),
        .rd_en   (walk_rd_en),
        .rd_addr (walk_addr),
        .rd_data (key_q)
    );

    chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_next (
        .clk     (clk),
        .wr_en   (next_wr_en),
        .wr_addr (idx_reg),
        .wr_data (head_value),
        .rd_en   (walk_rd_en),
        .rd_addr (walk_addr),
        .rd_data (next_q)
    );

    // back links are kept for later removal support; never read here
    chm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_prev (
        .clk     (clk),
        .wr_en   (prev_wr_en),
        .wr_addr (prev_addr),
        .wr_data (prev_data),
        .rd_en   (1'b0),
        .rd_addr (idx_reg),
        .rd_data ()
    );

    // chain choice from the finished hash
    always_comb
    begin
        lg_sat     = (log2_reg > LOG2_LIMIT) ? LOG2_LIMIT : log2_reg;
        chain_mask = ({{CHAIN_W{1'b0}}, 1'b1} << lg_sat) - {{CHAIN_W{1'b0}}, 1'b1};
        chain_sel  = hash_rsp.value[CHAIN_W-1:0] & chain_mask[CHAIN_W-1:0];
    end

    assign hash_din   = req.lookup_key ^ seed_reg;
    assign head_value = head_valid_reg[chain_reg] ? head_q : LINK_NIL;
    assign in_pool    = {1'b0, req.element_index} < POOL_LIMIT;
    assign steps_inc  = steps_reg + STEP_W'(1);

    always_comb
    begin
        state_next       = state_reg;
        head_valid_next  = head_valid_reg;
        req_type_next    = req_type_reg;
        idx_next         = idx_reg;
        key_next         = key_reg;
        chain_next       = chain_reg;
        cur_next         = cur_reg;
        steps_next       = steps_reg;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        hash_start       = 1'b0;
        head_rd_en       = 1'b0;
        head_wr_en       = 1'b0;
        key_wr_en        = 1'b0;
        walk_rd_en       = 1'b0;
        walk_addr        = head_value[IDX_W-1:0];
        next_wr_en       = 1'b0;
        prev_wr_en       = 1'b0;
        prev_addr        = idx_reg;
        prev_data        = LINK_NIL;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    req_type_next = req.req_type;
                    idx_next      = req.element_index;
                    key_next      = req.lookup_key;
                    if (req.req_type == REQ_INSERT && !in_pool)
                    begin
                        found_next       = 1'b0;
                        found_index_next = req.element_index;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        key_wr_en  = (req.req_type == REQ_INSERT);
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end

            ST_HASH:
            begin
                if (hash_rsp.done)
                begin
                    chain_next = chain_sel;
                    head_rd_en = 1'b1;
                    state_next = ST_HEAD;
                end
            end

            ST_HEAD:
            begin
                cur_next   = head_value;
                steps_next = '0;
                if (req_type_reg == REQ_INSERT)
                begin
                    head_wr_en                 = 1'b1;
                    head_valid_next[chain_reg] = 1'b1;
                    next_wr_en                 = 1'b1;
                    prev_wr_en                 = 1'b1;
                    if (head_value < POOL_LIMIT)
                    begin
                        state_next = ST_LINK;
                    end
                    else
                    begin
                        found_next       = 1'b1;
                        found_index_next = idx_reg;
                        state_next       = ST_DONE;
                    end
                end
                else if (head_value < POOL_LIMIT)
                begin
                    walk_rd_en = 1'b1;
                    state_next = ST_WALK;
                end
                else
                begin
                    found_next       = 1'b0;
                    found_index_next = '0;
                    state_next       = ST_DONE;
                end
            end

            ST_LINK:
            begin
                // point the old head back at the new one; a re-pushed head keeps null
                prev_wr_en       = (cur_reg[IDX_W-1:0] != idx_reg);
                prev_addr        = cur_reg[IDX_W-1:0];
                prev_data        = {1'b0, idx_reg};
                found_next       = 1'b1;
                found_index_next = idx_reg;
                state_next       = ST_DONE;
            end

            ST_WALK:
            begin
                if (key_q == key_reg)
                begin
                    found_next       = 1'b1;
                    found_index_next = cur_reg[IDX_W-1:0];
                    state_next       = ST_DONE;
                end
                else
                begin
                    cur_next   = next_q;
                    steps_next = steps_inc;
                    walk_addr  = next_q[IDX_W-1:0];
                    // stop at chain end or after a full pool of visits
                    if (next_q < POOL_LIMIT && steps_inc < STEP_LIMIT)
                    begin
                        walk_rd_en = 1'b1;
                    end
                    else
                    begin
                        found_next       = 1'b0;
                        found_index_next = '0;
                        state_next       = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_valid_reg <= '0;
            seed_reg       <= '0;
            log2_reg       <= LOG2_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.addr)
                    CFG_HASH_SEED:  seed_reg <= cfg.data;
                    CFG_CHAIN_LOG2: log2_reg <= cfg.data[LOG2_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg    <= req_type_next;
        idx_reg         <= idx_next;
        key_reg         <= key_next;
        chain_reg       <= chain_next;
        cur_reg         <= cur_next;
        steps_reg       <= steps_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = (state_reg == ST_DONE);
    assign rsp.found       = found_reg;
    assign rsp.found_index = found_index_reg;
    assign cfg.ready       = 1'b1;

endmodule

`default_nettype wire

// File: tb/sv/chained_hash_index_map_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_index_map_tb
// Self-checking regression for the chained hash index map. A behavioral
// copy of the map (mixer, chain choice, heads, keys and next links) predicts
// every answer when its request is taken. The answers are then checked in
// order against the response channel. Directed tests cover the field
// extremes, a shared chain, a circular chain and the chain count clamp.
// Random traffic then runs under changing seeds, chain counts and
// handshake pressure.
// ----------------------------------------------------------------------------

module chained_hash_index_map_tb;
    import chm_pkg::*;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] slot;
    } map_answer_t;

    // chain_count_log2 per random segment, segment 0 in the low nibble
    localparam logic [47:0] SEG_LOG2 = 48'h6947_2c51_f308;
    localparam int SEG_ITEMS = 78;
    localparam int RUN_LIMIT_NS = 60_000_000;

    logic clk = 1'b0;
    logic rst_n;

    chm_req_if req_if ();
    chm_rsp_if rsp_if ();
    chm_cfg_if cfg_if ();

    chained_hash_index_map i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // behavioral copy of the map
    logic [KEY_W-1:0]  model_seed;
    logic [LOG2_W-1:0] model_log2;
    logic [LINK_W-1:0] head_slot [MAX_CHAINS];
    logic [KEY_W-1:0]  slot_key [POOL_ENTRIES];
    logic [LINK_W-1:0] slot_next [POOL_ENTRIES];

    map_answer_t      answer_queue [$];
    map_answer_t      next_answer;
    logic [KEY_W-1:0] key_history [$];
    logic [IDX_W-1:0] slot_history [$];
    logic [IDX_W-1:0] fresh_slot = 10'd300;

    int req_idle_pct = 17;
    int rsp_stall_pct = 69;
    int error_count = 0;
    int insert_count = 0;
    int query_count = 0;
    int hit_count = 0;
    int config_writes = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] mix_key(input logic [KEY_W-1:0] x);
        logic [KEY_W-1:0] v;
        v = x ^ (x >> 33);
        v = v * MIX_C1;
        v = v ^ (v >> 33);
        v = v * MIX_C2;
        v = v ^ (v >> 33);
        return v;
    endfunction

    function automatic logic [CHAIN_W-1:0] chain_select(input logic [KEY_W-1:0] key);
        logic [LOG2_W-1:0] lg;
        logic [KEY_W-1:0]  mask;
        lg = (model_log2 > LOG2_LIMIT) ? LOG2_LIMIT : model_log2;
        mask = (64'd1 << lg) - 64'd1;
        return CHAIN_W'(mix_key(key ^ model_seed) & mask);
    endfunction

    function automatic map_answer_t predict_answer(input logic rtype,
                                                   input logic [IDX_W-1:0] slot,
                                                   input logic [KEY_W-1:0] key);
        map_answer_t        ans;
        logic [CHAIN_W-1:0] chain;
        logic [LINK_W-1:0]  cur;
        int                 steps;
        logic               hit;
        chain = chain_select(key);
        ans = '0;
        if (rtype == REQ_INSERT)
        begin
            slot_key[slot] = key;
            slot_next[slot] = head_slot[chain];
            head_slot[chain] = {1'b0, slot};
            ans.found = 1'b1;
            ans.slot = slot;
        end
        else
        begin
            cur = head_slot[chain];
            steps = 0;
            hit = 1'b0;
            // stop after one pass over the pool: a chain can loop
            while (!hit && cur < POOL_LIMIT && steps < POOL_ENTRIES)
            begin
                if (slot_key[cur[IDX_W-1:0]] == key)
                begin
                    hit = 1'b1;
                    ans.found = 1'b1;
                    ans.slot = cur[IDX_W-1:0];
                end
                else
                begin
                    cur = slot_next[cur[IDX_W-1:0]];
                    steps++;
                end
            end
        end
        return ans;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // favor recent keys so most lookups land on live chain entries
    function automatic logic [KEY_W-1:0] pick_known_key();
        int n;
        n = key_history.size();
        if (n > 32 && $urandom_range(9) < 7)
            return key_history[$urandom_range(n - 1, n - 32)];
        return key_history[$urandom_range(n - 1)];
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        error_count++;
        if (error_count <= 40)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic send_request(input logic rtype, input logic [IDX_W-1:0] slot,
                                input logic [KEY_W-1:0] key);
        map_answer_t ans;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= rtype;
        req_if.element_index <= slot;
        req_if.lookup_key    <= key;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        ans = predict_answer(rtype, slot, key);
        answer_queue.push_back(ans);
        if (rtype == REQ_INSERT)
        begin
            insert_count++;
            key_history.push_back(key);
            slot_history.push_back(slot);
        end
        else
        begin
            query_count++;
            if (ans.found)
                hit_count++;
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= addr;
        cfg_if.data  <= data;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge clk);
        if (addr == CFG_HASH_SEED)
            model_seed = data;
        else
            model_log2 = data[LOG2_W-1:0];
        config_writes++;
    endtask

    // drain, then write both registers back to back
    task automatic reconfigure(input logic [KEY_W-1:0] seed, input logic [LOG2_W-1:0] lg);
        logic [CFG_DATA_W-1:0] log2_word;
        req_if.valid <= 1'b0;
        while (answer_queue.size() != 0)
            @(posedge clk);
        log2_word = rand_key();
        log2_word[LOG2_W-1:0] = lg;
        write_register(CFG_HASH_SEED, seed);
        write_register(CFG_CHAIN_LOG2, log2_word);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random_item();
        logic [IDX_W-1:0] slot;
        logic [KEY_W-1:0] key;
        int               pick;
        int               how;
        pick = $urandom_range(99);
        how = $urandom_range(99);
        if (pick < 45)
        begin
            if (how < 85 || slot_history.size() == 0)
            begin
                slot = fresh_slot;
                fresh_slot++;
            end
            else if (how < 95)
                slot = slot_history[$urandom_range(slot_history.size() - 1)];
            else
                slot = IDX_W'($urandom_range(POOL_ENTRIES - 1));
            key = ($urandom_range(9) == 0) ? pick_known_key() : rand_key();
            send_request(REQ_INSERT, slot, key);
        end
        else
        begin
            key = (pick < 85) ? pick_known_key() : rand_key();
            send_request(REQ_QUERY, IDX_W'($urandom_range(POOL_ENTRIES - 1)), key);
        end
    endtask

    // reset configuration: seed 0, 256 chains
    task automatic test_reset_defaults();
        send_request(REQ_INSERT, 10'd0, 64'd0);
        send_request(REQ_INSERT, 10'd1023, '1);
        send_request(REQ_INSERT, 10'd512, 64'h5555_5555_5555_5555);
        send_request(REQ_QUERY, 10'd1023, 64'h5555_5555_5555_5555);
        send_request(REQ_QUERY, 10'd0, 64'd0);
        send_request(REQ_QUERY, 10'h155, '1);
        send_request(REQ_QUERY, 10'h2aa, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    // one chain: every slot lands on it, walks get deep
    task automatic test_shared_chain();
        logic [KEY_W-1:0] k [5];
        reconfigure(rand_key(), 4'd0);
        for (int i = 0; i < 5; i++)
        begin
            k[i] = rand_key();
            send_request(REQ_INSERT, IDX_W'(100 + i), k[i]);
        end
        send_request(REQ_QUERY, 10'd0, k[0]);
        send_request(REQ_QUERY, 10'd0, k[4]);
        send_request(REQ_QUERY, 10'd0, rand_key());
    endtask

    // re-push a linked slot to close a loop, then re-push it for a self loop
    task automatic test_walk_cap();
        logic [KEY_W-1:0] last_key;
        send_request(REQ_INSERT, 10'd102, rand_key());
        send_request(REQ_QUERY, 10'd0, rand_key());
        last_key = rand_key();
        send_request(REQ_INSERT, 10'd102, last_key);
        send_request(REQ_QUERY, 10'd0, rand_key());
        send_request(REQ_QUERY, 10'd0, last_key);
    endtask

    // oversized chain count clamps; old entries stay where they were put
    task automatic test_chain_log2_saturation();
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        ka = rand_key();
        kb = rand_key();
        reconfigure('1, 4'd15);
        send_request(REQ_INSERT, 10'd200, ka);
        send_request(REQ_INSERT, 10'd201, kb);
        send_request(REQ_QUERY, 10'd0, kb);
        send_request(REQ_QUERY, 10'd0, ka);
        send_request(REQ_QUERY, 10'd0, '1);
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                       input int first_seg);
        logic [KEY_W-1:0] seed;
        req_idle_pct = send_idle;
        rsp_stall_pct = recv_stall;
        for (int seg = first_seg; seg < first_seg + 4; seg++)
        begin
            case (seg % 3)
                0: seed = rand_key();
                1: seed = '0;
                default: seed = '1;
            endcase
            reconfigure(seed, SEG_LOG2[seg*4 +: 4]);
            repeat (SEG_ITEMS) send_random_item();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                if (answer_queue.size() == 0)
                    report_mismatch("unrequested result", 64'(rsp_if.found_index), 64'd0);
                else
                begin
                    next_answer = answer_queue.pop_front();
                    if (rsp_if.found !== next_answer.found)
                        report_mismatch("found", 64'(rsp_if.found), 64'(next_answer.found));
                    if (rsp_if.found_index !== next_answer.slot)
                        report_mismatch("found_index", 64'(rsp_if.found_index),
                                        64'(next_answer.slot));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_INSERT;
        req_if.element_index = '0;
        req_if.lookup_key = '0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = CFG_HASH_SEED;
        cfg_if.data = '0;
        model_seed = '0;
        model_log2 = LOG2_RESET;
        for (int i = 0; i < MAX_CHAINS; i++)
            head_slot[i] = LINK_NIL;
        for (int i = 0; i < POOL_ENTRIES; i++)
        begin
            slot_key[i] = '0;
            slot_next[i] = LINK_NIL;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_shared_chain();
        test_walk_cap();
        test_chain_log2_saturation();
        test_random_traffic(17, 69, 0);
        test_random_traffic(69, 17, 4);
        test_random_traffic(0, 0, 8);

        req_if.valid <= 1'b0;
        while (answer_queue.size() != 0)
            @(posedge clk);
        // hold a little longer to catch stray results
        repeat (40) @(posedge clk);

        $display("covered %0d inserts and %0d lookups (%0d hits), %0d register writes",
                 insert_count, query_count, hit_count, config_writes);
        $display("seeds 0, all ones and random; chain counts 1 to 256 plus clamp; ",
                 "looped chains; three handshake pressure mixes");
        if (error_count == 0)
            $display("chained_hash_index_map regression: pass");
        else
            $display("chained_hash_index_map regression: fail");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("chained_hash_index_map regression: fail");
        $finish;
    end

endmodule

// File: chained_hash_index_map.f
rtl/core/chm_pkg.sv
rtl/core/chm_req_if.sv
rtl/core/chm_rsp_if.sv
rtl/core/chm_cfg_if.sv
rtl/core/chm_ram.sv
rtl/core/chm_hash.sv
rtl/core/chained_hash_index_map.sv
tb/sv/chained_hash_index_map_tb.sv
